// File: rtl/core/bts_pkg.sv
package bts_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_TRIGGER = 2'd1,
        OP_STOP    = 2'd2,
        OP_QUERY   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        TONE_BEEP     = 2'd0,
        TONE_DOORBELL = 2'd1,
        TONE_ALARM    = 2'd2,
        TONE_UNKNOWN  = 2'd3
    } t_tone;

    typedef enum logic [1:0] {
        REP_NONE = 2'd0,
        REP_ON   = 2'd1,
        REP_OFF  = 2'd2
    } t_report;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOORBELL_PERIOD = 3'd0,
        CFG_DOORBELL_COUNT  = 3'd1,
        CFG_ALARM_PERIOD    = 3'd2,
        CFG_ALARM_DEFAULT   = 3'd3,
        CFG_MAX_DURATION    = 3'd4
    } t_cfg_idx;

    localparam logic [9:0]  RST_DOORBELL_PERIOD = 10'd200;
    localparam logic [3:0]  RST_DOORBELL_COUNT  = 4'd2;
    localparam logic [9:0]  RST_ALARM_PERIOD    = 10'd250;
    localparam logic [7:0]  RST_ALARM_DEFAULT   = 8'd10;
    localparam logic [7:0]  RST_MAX_DURATION    = 8'd120;
    localparam logic [17:0] MS_PER_S            = 18'd1000;

    typedef struct packed {
        logic    chirp;
        logic    force_quiet;
        t_report report;
        t_tone   report_tone;
        logic    last;
    } t_result;

    // Up to two results come out of one request.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_res_pair;

endpackage

// File: rtl/core/bts_if.sv
interface bts_req_if import bts_pkg::*; ();
    logic               valid;
    logic               ready;
    t_op                operation;
    t_tone              tone;
    logic signed [15:0] alarm_secs;

    modport source (output valid, output operation, output tone, output alarm_secs,
                    input ready);
    modport sink   (input valid, input operation, input tone, input alarm_secs,
                    output ready);
endinterface

interface bts_res_if import bts_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    chirp;
    logic    force_quiet;
    t_report report;
    t_tone   report_tone;
    logic    last;

    modport source (output valid, output chirp, output force_quiet, output report,
                    output report_tone, output last, input ready);
    modport sink   (input valid, input chirp, input force_quiet, input report,
                    input report_tone, input last, output ready);
endinterface

interface bts_cfg_if import bts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/bts_core.sv
module bts_core import bts_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_req_fire,
    input  t_op                   i_operation,
    input  t_tone                 i_tone,
    input  logic signed [15:0]    i_alarm_secs,
    output t_res_pair             o_res
);

    logic [9:0]  r_door_period;
    logic [3:0]  r_door_count;
    logic [9:0]  r_alarm_period;
    logic [7:0]  r_alarm_default;
    logic [7:0]  r_max_duration;

    logic        r_active,    n_active;
    t_tone       r_cur_tone,  n_cur_tone;
    logic [3:0]  r_chirps,    n_chirps;
    logic [9:0]  r_phase,     n_phase;
    logic [17:0] r_elapsed,   n_elapsed;
    logic [17:0] r_limit,     n_limit;

    logic        is_alarm;
    logic [9:0]  period;
    logic [9:0]  phase_inc;
    logic [17:0] elapsed_inc;
    t_tone       tone_eff;
    logic [15:0] req_secs;
    logic [7:0]  secs;
    logic [17:0] limit_calc;

    localparam t_result RES_CHIRP = '{chirp: 1'b1, force_quiet: 1'b0, report: REP_NONE,
                                      report_tone: TONE_BEEP, last: 1'b1};
    localparam t_result RES_FINISH = '{chirp: 1'b0, force_quiet: 1'b1, report: REP_OFF,
                                       report_tone: TONE_BEEP, last: 1'b1};
    localparam t_result RES_OFF = '{chirp: 1'b0, force_quiet: 1'b0, report: REP_OFF,
                                    report_tone: TONE_BEEP, last: 1'b1};

    always_comb begin
        is_alarm    = (r_cur_tone == TONE_ALARM);
        period      = is_alarm ? r_alarm_period : r_door_period;
        phase_inc   = r_phase + 10'd1;
        elapsed_inc = (is_alarm && (r_elapsed < r_limit)) ? r_elapsed + 18'd1 : r_elapsed;
        tone_eff    = (i_tone == TONE_UNKNOWN) ? TONE_BEEP : i_tone;
        // A zero or negative request falls back to the default duration.
        req_secs    = ((i_alarm_secs == 16'sd0) || i_alarm_secs[15]) ?
                      {8'd0, r_alarm_default} : 16'(unsigned'(i_alarm_secs));
        secs        = (req_secs > {8'd0, r_max_duration}) ? r_max_duration : req_secs[7:0];
        limit_calc  = 18'(secs) * MS_PER_S;
    end

    always_comb begin
        n_active   = r_active;
        n_cur_tone = r_cur_tone;
        n_chirps   = r_chirps;
        n_phase    = r_phase;
        n_elapsed  = r_elapsed;
        n_limit    = r_limit;
        o_res.cnt  = 2'd0;
        o_res.res0 = RES_OFF;
        o_res.res1 = RES_OFF;
        if (i_req_fire) begin
            unique case (i_operation)
                OP_TICK: begin
                    if (r_active) begin
                        n_elapsed = elapsed_inc;
                        n_phase   = phase_inc;
                        if (phase_inc >= period) begin
                            n_phase   = 10'd0;
                            o_res.cnt = 2'd1;
                            if (is_alarm ? (elapsed_inc >= r_limit) : (r_chirps == 4'd0)) begin
                                n_active   = 1'b0;
                                o_res.res0 = RES_FINISH;
                            end else begin
                                if (!is_alarm) begin
                                    n_chirps = r_chirps - 4'd1;
                                end
                                o_res.res0 = RES_CHIRP;
                            end
                        end
                    end
                end
                OP_STOP: begin
                    n_active   = 1'b0;
                    o_res.cnt  = 2'd1;
                    o_res.res0 = RES_FINISH;
                end
                OP_QUERY: begin
                    o_res.cnt = 2'd1;
                    if (r_active) begin
                        o_res.res0 = '{chirp: 1'b0, force_quiet: 1'b0, report: REP_ON,
                                       report_tone: r_cur_tone, last: 1'b1};
                    end
                end
                OP_TRIGGER: begin
                    o_res.res0 = '{chirp: 1'b1, force_quiet: 1'b0, report: REP_ON,
                                   report_tone: tone_eff, last: 1'b1};
                    if ((tone_eff == TONE_BEEP) ||
                        ((tone_eff == TONE_DOORBELL) && (r_door_count <= 4'd1))) begin
                        // One-shot tones report on and off in the same request.
                        n_active        = 1'b0;
                        o_res.cnt       = 2'd2;
                        o_res.res0.last = 1'b0;
                    end else begin
                        n_active   = 1'b1;
                        n_cur_tone = tone_eff;
                        n_phase    = 10'd0;
                        o_res.cnt  = 2'd1;
                        if (tone_eff == TONE_ALARM) begin
                            n_limit   = limit_calc;
                            n_elapsed = 18'd0;
                        end else begin
                            n_chirps = r_door_count - 4'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_door_period   <= RST_DOORBELL_PERIOD;
            r_door_count    <= RST_DOORBELL_COUNT;
            r_alarm_period  <= RST_ALARM_PERIOD;
            r_alarm_default <= RST_ALARM_DEFAULT;
            r_max_duration  <= RST_MAX_DURATION;
            r_active        <= 1'b0;
            r_cur_tone      <= TONE_BEEP;
            r_chirps        <= 4'd0;
            r_phase         <= 10'd0;
            r_elapsed       <= 18'd0;
            r_limit         <= 18'd0;
        end else begin
            r_active   <= n_active;
            r_cur_tone <= n_cur_tone;
            r_chirps   <= n_chirps;
            r_phase    <= n_phase;
            r_elapsed  <= n_elapsed;
            r_limit    <= n_limit;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DOORBELL_PERIOD: r_door_period   <= i_cfg_data;
                    CFG_DOORBELL_COUNT:  r_door_count    <= i_cfg_data[3:0];
                    CFG_ALARM_PERIOD:    r_alarm_period  <= i_cfg_data;
                    CFG_ALARM_DEFAULT:   r_alarm_default <= i_cfg_data[7:0];
                    CFG_MAX_DURATION:    r_max_duration  <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// File: rtl/core/bts_res_fifo.sv
module bts_res_fifo import bts_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res_pair i_push,
    input  logic      i_pop,
    output t_result   o_head,
    output logic      o_valid,
    output logic      o_room
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [PTR_W-1:0] wp1;
    logic             pop_ok;

    always_comb begin
        pop_ok = i_pop && (r_cnt != '0);
        wp1    = (r_wp == LAST_PTR) ? '0 : r_wp + PTR_W'(1);
        n_rp   = r_rp;
        if (pop_ok) begin
            n_rp = (r_rp == LAST_PTR) ? '0 : r_rp + PTR_W'(1);
        end
        unique case (i_push.cnt)
            2'd1:    n_wp = wp1;
            2'd2:    n_wp = (wp1 == LAST_PTR) ? '0 : wp1 + PTR_W'(1);
            default: n_wp = r_wp;
        endcase
        n_cnt = r_cnt + CNT_W'(i_push.cnt) - CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wp1] <= i_push.res1;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_valid = (r_cnt != '0);
    // A new request is taken only while two free slots remain.
    assign o_room  = (r_cnt <= ROOM_MAX);

endmodule

// File: rtl/core/buzzer_tone_sequencer.sv
// Buzzer tone sequencer. Each request is a 1 ms tick, a trigger, a stop or a
// status query, and is worked out combinationally: the tone counters and
// their compares sit between the state registers and a small result queue of
// RES_DEPTH entries (at least 2). A one-shot trigger yields two results and
// every other request at most one, and the queue drains one result per cycle
// while results are taken. With three or more queue entries the request side
// sustains one request per cycle while each request yields at most one result
// and results are taken at once; a run of one-shot triggers is held back.
// Ready drops while fewer than two queue slots are free. Configuration writes
// are always ready and take effect on the next cycle.
module buzzer_tone_sequencer import bts_pkg::*; #(
    parameter int RES_DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bts_req_if.sink   i_req,
    bts_cfg_if.sink   i_cfg,
    bts_res_if.source o_res
);

    t_res_pair core_res;
    t_result   head;
    logic      room;
    logic      head_valid;
    logic      req_fire;

    assign req_fire    = i_req.valid && room;
    assign i_req.ready = room;
    assign i_cfg.ready = 1'b1;

    bts_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_req_fire   (req_fire),
        .i_operation  (i_req.operation),
        .i_tone       (i_req.tone),
        .i_alarm_secs (i_req.alarm_secs),
        .o_res        (core_res)
    );

    bts_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_res),
        .i_pop   (o_res.ready),
        .o_head  (head),
        .o_valid (head_valid),
        .o_room  (room)
    );

    assign o_res.valid       = head_valid;
    assign o_res.chirp       = head.chirp;
    assign o_res.force_quiet = head.force_quiet;
    assign o_res.report      = head.report;
    assign o_res.report_tone = head.report_tone;
    assign o_res.last        = head.last;

endmodule

// File: rtl/core/bts_checker.sv
module bts_checker import bts_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_req_valid,
    input logic    i_req_ready,
    input t_op     i_req_operation,
    input logic    i_res_valid,
    input logic    i_res_ready,
    input logic    i_res_chirp,
    input logic    i_res_force_quiet,
    input t_report i_res_report
);

    // A waiting result is not withdrawn.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result valid dropped before it was taken");

    // Back pressure only arises from results that are waiting.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> i_res_valid)
        else $error("request side stalled with no pending result");

    // A stop request always yields a result on the next cycle.
    a_stop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_operation == OP_STOP) |=> i_res_valid)
        else $error("stop request produced no result");

    // Forcing quiet only comes with an off report and never with a chirp.
    a_quiet_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_force_quiet |-> (i_res_report == REP_OFF) && !i_res_chirp)
        else $error("force_quiet result is not a plain off report");

endmodule

bind buzzer_tone_sequencer bts_checker u_bts_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_req_operation   (i_req.operation),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_chirp       (o_res.chirp),
    .i_res_force_quiet (o_res.force_quiet),
    .i_res_report      (o_res.report)
);

// File: bench/buzzer_tone_sequencer_test.sv
`timescale 1ns / 1ps

module buzzer_tone_sequencer_test;
    import bts_pkg::*;

    localparam int PLAN_ROWS     = 22;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;

    typedef struct {
        t_op                op;
        t_tone              tn;
        logic signed [15:0] dur;
        bit                 fixed;
        int                 n;
        t_result            r0;
        t_result            r1;
    } t_plan_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bts_req_if req_bus ();
    bts_cfg_if cfg_bus ();
    bts_res_if res_bus ();

    buzzer_tone_sequencer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    always #10 i_clk = ~i_clk;

    // Mirror of the sequencer state and its registers.
    logic        seq_active    = 1'b0;
    t_tone       seq_tone      = TONE_BEEP;
    logic [3:0]  bell_left     = '0;
    logic [9:0]  seq_phase     = '0;
    logic [17:0] alarm_elapsed = '0;
    logic [17:0] alarm_limit   = '0;

    logic [9:0] bell_period_reg   = RST_DOORBELL_PERIOD;
    logic [3:0] bell_count_reg    = RST_DOORBELL_COUNT;
    logic [9:0] alarm_period_reg  = RST_ALARM_PERIOD;
    logic [7:0] alarm_default_reg = RST_ALARM_DEFAULT;
    logic [7:0] max_dur_reg       = RST_MAX_DURATION;

    t_result   buzz_due[$];
    t_plan_row plan[PLAN_ROWS];

    bit      use_fixed = 1'b0;
    int      fixed_n;
    t_result fixed_r0, fixed_r1;

    bit hold_results = 1'b0;
    bit req_burst    = 1'b0;
    bit res_burst    = 1'b0;
    int req_sent     = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    function automatic t_result buzz_result(logic c, logic q, t_report rp, t_tone tt, logic l);
        t_result r;
        r.chirp       = c;
        r.force_quiet = q;
        r.report      = rp;
        r.report_tone = tt;
        r.last        = l;
        return r;
    endfunction

    task automatic step_sequencer(input t_op op, input t_tone tn, input logic [15:0] dur,
                                  output int n, output t_result r0, output t_result r1);
        logic [9:0] period;
        logic       is_alarm;
        t_tone      t;
        int         secs;
        n  = 0;
        r0 = '0;
        r1 = '0;
        case (op)
            OP_TICK: begin
                if (seq_active) begin
                    is_alarm = (seq_tone == TONE_ALARM);
                    period   = is_alarm ? alarm_period_reg : bell_period_reg;
                    if (is_alarm && alarm_elapsed < alarm_limit)
                        alarm_elapsed = alarm_elapsed + 18'd1;
                    seq_phase = seq_phase + 10'd1;
                    // A zero period never holds the phase back, so it behaves as one.
                    if (seq_phase >= period) begin
                        seq_phase = '0;
                        n = 1;
                        if (is_alarm ? (alarm_elapsed >= alarm_limit) : (bell_left == 4'd0)) begin
                            seq_active = 1'b0;
                            r0 = buzz_result(1'b0, 1'b1, REP_OFF, TONE_BEEP, 1'b1);
                        end else begin
                            if (!is_alarm)
                                bell_left = bell_left - 4'd1;
                            r0 = buzz_result(1'b1, 1'b0, REP_NONE, TONE_BEEP, 1'b1);
                        end
                    end
                end
            end
            OP_TRIGGER: begin
                seq_active = 1'b0;
                t = (tn == TONE_UNKNOWN) ? TONE_BEEP : tn;
                if (t == TONE_BEEP || (t == TONE_DOORBELL && bell_count_reg <= 4'd1)) begin
                    n  = 2;
                    r0 = buzz_result(1'b1, 1'b0, REP_ON, t, 1'b0);
                    r1 = buzz_result(1'b0, 1'b0, REP_OFF, TONE_BEEP, 1'b1);
                end else begin
                    seq_tone  = t;
                    seq_phase = '0;
                    if (t == TONE_ALARM) begin
                        if (dur == 16'd0 || dur[15])
                            secs = alarm_default_reg;
                        else
                            secs = dur;
                        if (secs > max_dur_reg)
                            secs = max_dur_reg;
                        alarm_limit   = 18'(secs) * MS_PER_S;
                        alarm_elapsed = '0;
                    end else begin
                        bell_left = bell_count_reg - 4'd1;
                    end
                    seq_active = 1'b1;
                    n  = 1;
                    r0 = buzz_result(1'b1, 1'b0, REP_ON, t, 1'b1);
                end
            end
            OP_STOP: begin
                seq_active = 1'b0;
                n  = 1;
                r0 = buzz_result(1'b0, 1'b1, REP_OFF, TONE_BEEP, 1'b1);
            end
            OP_QUERY: begin
                n = 1;
                if (seq_active)
                    r0 = buzz_result(1'b0, 1'b0, REP_ON, seq_tone, 1'b1);
                else
                    r0 = buzz_result(1'b0, 1'b0, REP_OFF, TONE_BEEP, 1'b1);
            end
        endcase
    endtask

    function automatic t_plan_row plan_row(t_op op, t_tone tn, int dur, bit fixed, int n,
                                           t_result r0, t_result r1);
        t_plan_row row;
        row.op    = op;
        row.tn    = tn;
        row.dur   = 16'(dur);
        row.fixed = fixed;
        row.n     = n;
        row.r0    = r0;
        row.r1    = r1;
        return row;
    endfunction

    // Directed rows run under the reset settings.
    function automatic void load_plan();
        t_result none, off, quiet, on_beep, ring_bell, ring_alarm, is_bell, is_alarm;
        none       = '0;
        off        = buzz_result(1'b0, 1'b0, REP_OFF, TONE_BEEP, 1'b1);
        quiet      = buzz_result(1'b0, 1'b1, REP_OFF, TONE_BEEP, 1'b1);
        on_beep    = buzz_result(1'b1, 1'b0, REP_ON, TONE_BEEP, 1'b0);
        ring_bell  = buzz_result(1'b1, 1'b0, REP_ON, TONE_DOORBELL, 1'b1);
        ring_alarm = buzz_result(1'b1, 1'b0, REP_ON, TONE_ALARM, 1'b1);
        is_bell    = buzz_result(1'b0, 1'b0, REP_ON, TONE_DOORBELL, 1'b1);
        is_alarm   = buzz_result(1'b0, 1'b0, REP_ON, TONE_ALARM, 1'b1);
        plan[0]  = plan_row(OP_QUERY,   TONE_BEEP,     0,      1, 1, off, none);
        plan[1]  = plan_row(OP_TICK,    TONE_BEEP,     0,      1, 0, none, none);
        plan[2]  = plan_row(OP_STOP,    TONE_BEEP,     0,      1, 1, quiet, none);
        plan[3]  = plan_row(OP_TRIGGER, TONE_BEEP,     0,      1, 2, on_beep, off);
        plan[4]  = plan_row(OP_TRIGGER, TONE_UNKNOWN,  -1,     1, 2, on_beep, off);
        plan[5]  = plan_row(OP_TRIGGER, TONE_DOORBELL, 0,      1, 1, ring_bell, none);
        plan[6]  = plan_row(OP_QUERY,   TONE_UNKNOWN,  32767,  1, 1, is_bell, none);
        plan[7]  = plan_row(OP_TICK,    TONE_ALARM,    1,      0, 0, none, none);
        plan[8]  = plan_row(OP_TRIGGER, TONE_ALARM,    -32768, 1, 1, ring_alarm, none);
        plan[9]  = plan_row(OP_QUERY,   TONE_BEEP,     0,      1, 1, is_alarm, none);
        plan[10] = plan_row(OP_TRIGGER, TONE_ALARM,    32767,  1, 1, ring_alarm, none);
        plan[11] = plan_row(OP_TICK,    TONE_ALARM,    -1,     0, 0, none, none);
        plan[12] = plan_row(OP_STOP,    TONE_ALARM,    0,      1, 1, quiet, none);
        plan[13] = plan_row(OP_QUERY,   TONE_BEEP,     0,      1, 1, off, none);
        plan[14] = plan_row(OP_TRIGGER, TONE_ALARM,    0,      1, 1, ring_alarm, none);
        plan[15] = plan_row(OP_TRIGGER, TONE_ALARM,    1,      1, 1, ring_alarm, none);
        plan[16] = plan_row(OP_TRIGGER, TONE_BEEP,     32767,  1, 2, on_beep, off);
        plan[17] = plan_row(OP_QUERY,   TONE_ALARM,    5,      1, 1, off, none);
        plan[18] = plan_row(OP_TICK,    TONE_UNKNOWN,  -1,     1, 0, none, none);
        plan[19] = plan_row(OP_TRIGGER, TONE_DOORBELL, 1,      1, 1, ring_bell, none);
        plan[20] = plan_row(OP_STOP,    TONE_DOORBELL, 7,      1, 1, quiet, none);
        plan[21] = plan_row(OP_TICK,    TONE_DOORBELL, 0,      1, 0, none, none);
    endfunction

    function automatic logic signed [15:0] pick_duration();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'sd0;
            2: return {1'b1, 15'($urandom)};
            default: return 16'($urandom_range(1, 3));
        endcase
    endfunction

    // The gap that follows a request is drawn once it is taken, so valid stays
    // high across back-to-back requests.
    task automatic push_req(input t_op op, input t_tone tn, input logic signed [15:0] dur);
        int gap;
        req_bus.valid      <= 1'b1;
        req_bus.operation  <= op;
        req_bus.tone       <= tn;
        req_bus.alarm_secs <= dur;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        @(negedge i_clk);
        req_sent++;
        if ($urandom_range(0, 39) == 0)
            req_burst = !req_burst;
        gap = req_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic play_tone(input t_tone tn, input logic signed [15:0] dur, input int ticks,
                             input bit breakable);
        int roll;
        push_req(OP_TRIGGER, tn, dur);
        for (int k = 0; k < ticks; k++) begin
            roll = $urandom_range(0, 63);
            if (roll < 4)
                push_req(OP_QUERY, t_tone'($urandom_range(0, 3)), 16'($urandom));
            else if (roll == 4 && breakable)
                push_req(OP_STOP, t_tone'($urandom_range(0, 3)), 16'($urandom));
            else
                push_req(OP_TICK, t_tone'($urandom_range(0, 3)), 16'($urandom));
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        while (buzz_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input int bp, input int bc, input int ap, input int ad,
                             input int md, input int goal, input int run_max,
                             input bit squeeze);
        int start;
        int budget;
        req_bus.valid <= 1'b0;
        drain_results();
        write_reg(CFG_DOORBELL_PERIOD, bp);
        write_reg(CFG_DOORBELL_COUNT, bc);
        write_reg(CFG_ALARM_PERIOD, ap);
        write_reg(CFG_ALARM_DEFAULT, ad);
        write_reg(CFG_MAX_DURATION, md);
        cfg_bus.valid <= 1'b0;
        if (squeeze)
            hold_results = 1'b1;
        start = req_sent;
        // Mostly a trigger followed by a run of ticks; the rest is loose requests.
        while (req_sent - start < goal) begin
            budget = goal - (req_sent - start) - 1;
            if ($urandom_range(0, 99) < 85)
                play_tone(t_tone'($urandom_range(0, 3)), pick_duration(),
                          $urandom_range(0, (run_max < budget) ? run_max : budget), 1'b1);
            else
                push_req(t_op'($urandom_range(0, 3)), t_tone'($urandom_range(0, 3)),
                         pick_duration());
        end
    endtask

    always @(posedge i_clk) begin
        int      n;
        t_result r0, r1;
        if (i_rst_n && req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            step_sequencer(req_bus.operation, req_bus.tone, req_bus.alarm_secs, n, r0, r1);
            if (use_fixed) begin
                n  = fixed_n;
                r0 = fixed_r0;
                r1 = fixed_r1;
            end
            if (n > 0)
                buzz_due.push_back(r0);
            if (n > 1)
                buzz_due.push_back(r1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1) begin
            case (t_cfg_idx'(cfg_bus.index))
                CFG_DOORBELL_PERIOD: bell_period_reg   = cfg_bus.data[9:0];
                CFG_DOORBELL_COUNT:  bell_count_reg    = cfg_bus.data[3:0];
                CFG_ALARM_PERIOD:    alarm_period_reg  = cfg_bus.data[9:0];
                CFG_ALARM_DEFAULT:   alarm_default_reg = cfg_bus.data[7:0];
                CFG_MAX_DURATION:    max_dur_reg       = cfg_bus.data[7:0];
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            got = buzz_result(res_bus.chirp, res_bus.force_quiet, res_bus.report,
                              res_bus.report_tone, res_bus.last);
            if (buzz_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result chirp=%0b quiet=%0b report=%0d tone=%0d last=%0b",
                             $realtime, got.chirp, got.force_quiet, got.report,
                             got.report_tone, got.last);
            end else begin
                want = buzz_due.pop_front();
                if (got.chirp !== want.chirp || got.force_quiet !== want.force_quiet ||
                    got.report !== want.report || got.report_tone !== want.report_tone ||
                    got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: expected %0b/%0b/%0d/%0d/%0b got %0b/%0b/%0d/%0d/%0b %s",
                                 $realtime, want.chirp, want.force_quiet, want.report,
                                 want.report_tone, want.last, got.chirp, got.force_quiet,
                                 got.report, got.report_tone, got.last,
                                 "(chirp/quiet/report/tone/last)");
                end
            end
        end
    end

    // Ends the run when no request, result or register write moves for too long.
    always @(posedge i_clk) begin
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) ||
            (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[buzzer_tone_sequencer] ERROR");
                $finish;
            end
        end
    end

    initial begin
        int gap;
        res_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_results) begin
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_results = 1'b0;
            end
            if ($urandom_range(0, 39) == 0)
                res_burst = !res_burst;
            gap = res_burst ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                res_bus.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (res_bus.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    initial begin
        req_bus.valid      = 1'b0;
        req_bus.operation  = OP_TICK;
        req_bus.tone       = TONE_BEEP;
        req_bus.alarm_secs = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = '0;
        cfg_bus.data       = '0;
        load_plan();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) begin
            use_fixed = plan[i].fixed;
            fixed_n   = plan[i].n;
            fixed_r0  = plan[i].r0;
            fixed_r1  = plan[i].r1;
            push_req(plan[i].op, plan[i].tn, plan[i].dur);
        end
        use_fixed = 1'b0;

        run_phase(RST_DOORBELL_PERIOD, RST_DOORBELL_COUNT, RST_ALARM_PERIOD,
                  RST_ALARM_DEFAULT, RST_MAX_DURATION, 220, 210, 1'b0);
        run_phase(3, 4, 7, 1, 1, 80, 40, 1'b0);
        run_phase(1, 15, 1, 255, 255, 100, 30, 1'b1);
        run_phase(1023, 2, 1, 1, 255, 40, 20, 1'b0);
        // Zero periods, a zero second alarm and a doorbell of no repeats.
        run_phase(0, 0, 0, 0, 0, 50, 6, 1'b0);
        run_phase(2, 1, 3, 5, 2, 50, 12, 1'b0);
        repeat (2)
            run_phase($urandom_range(1, 12), $urandom_range(2, 15), $urandom_range(1, 12),
                      $urandom_range(1, 255), $urandom_range(1, 255), 50, 30, 1'b0);

        req_bus.valid <= 1'b0;
        drain_results();
        repeat (10) @(negedge i_clk);
        if (buzz_due.size() != 0)
            mismatches += buzz_due.size();
        if (mismatches == 0)
            $display("[buzzer_tone_sequencer] OK");
        else
            $display("[buzzer_tone_sequencer] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/bts_pkg.sv
rtl/core/bts_if.sv
rtl/core/bts_core.sv
rtl/core/bts_res_fifo.sv
rtl/core/buzzer_tone_sequencer.sv
rtl/core/bts_checker.sv
bench/buzzer_tone_sequencer_test.sv
